// ===== design/sufdiv_pkg.sv =====
`timescale 1ns / 1ps

package sufdiv_pkg;

   localparam int DATA_WIDTH = 32;

   // Operation select on req_type
   localparam logic OP_SIGNED   = 1'b0;
   localparam logic OP_UNSIGNED = 1'b1;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;   // partial remainder
      logic [DATA_WIDTH-1:0] nq;    // dividend bits still to go, quotient bits shifted in below
      logic [DATA_WIDTH-1:0] dsr;   // divisor magnitude
      logic                  neg_a; // dividend negative (signed mode only)
      logic                  neg_b; // divisor negative (signed mode only)
   } stage_type;

endpackage

// ===== design/signed_unsigned_floor_divider.sv =====
`timescale 1ns / 1ps

// Pipelined divider giving quotient and remainder of two DATA_WIDTH-bit words, either
// unsigned (req_type high) or signed with floor rounding (req_type low), where the
// remainder takes the sign of the divisor. It takes one transaction per cycle while
// rsp_ready stays high; each request passes through an input register that takes operand
// magnitudes, one cell per quotient bit of the restoring array, and an output register of
// sign correction. Every stage holds its own valid bit, so gaps close up under
// back-pressure. A zero divisor is not trapped: unsigned gives all ones and the dividend;
// signed gives all ones (or zero for a negative dividend) and the dividend.
module signed_unsigned_floor_divider
   import sufdiv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   input  logic                  req_type,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [DATA_WIDTH-1:0] rsp_remainder
);

   logic      pre_valid_ff;
   stage_type pre_data_ff;
   stage_type pre_data_in;
   logic      signed_op;

   logic      chain_valid [DATA_WIDTH+1];
   logic      chain_ready [DATA_WIDTH+1];
   stage_type chain_data  [DATA_WIDTH+1];

   // Operand magnitudes
   always_comb begin
      signed_op         = (req_type == OP_SIGNED);
      pre_data_in.neg_a = signed_op && req_dividend[DATA_WIDTH-1];
      pre_data_in.neg_b = signed_op && req_divisor[DATA_WIDTH-1];
      pre_data_in.nq    = pre_data_in.neg_a ? ('0 - req_dividend) : req_dividend;
      pre_data_in.dsr   = pre_data_in.neg_b ? ('0 - req_divisor) : req_divisor;
      pre_data_in.rem   = '0;
   end

   assign req_ready = !pre_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (req_ready) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pre_data_ff <= pre_data_in;
      end
   end

   assign chain_valid[0] = pre_valid_ff;
   assign chain_data[0]  = pre_data_ff;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sufdiv_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   sufdiv_fixup u_fixup (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[DATA_WIDTH]),
      .in_ready      (chain_ready[DATA_WIDTH]),
      .in_data       (chain_data[DATA_WIDTH]),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_quotient  (rsp_quotient),
      .out_remainder (rsp_remainder)
   );

endmodule

// ===== design/sufdiv_cell.sv =====
`timescale 1ns / 1ps

module sufdiv_cell
   import sufdiv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic                  valid_ff;
   stage_type             data_ff;
   stage_type             data_in;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;

   // One restoring step: shift in the next dividend bit, trial subtract, keep or restore
   always_comb begin
      shifted = {in_data.rem[DATA_WIDTH-2:0], in_data.nq[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, in_data.dsr};
      data_in = in_data;
      data_in.rem = diff[DATA_WIDTH] ? shifted : diff[DATA_WIDTH-1:0];
      data_in.nq  = {in_data.nq[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/sufdiv_fixup.sv =====
`timescale 1ns / 1ps

module sufdiv_fixup
   import sufdiv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  stage_type             in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_quotient,
   output logic [DATA_WIDTH-1:0] out_remainder
);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] quo_ff;
   logic [DATA_WIDTH-1:0] quo_in;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] sub_a;
   logic [DATA_WIDTH-1:0] sub_b;
   logic                  rem_nz;
   logic                  differ;

   // Floor correction folded into one negate/decrement and one subtract:
   // -q - 1 is ~q, and -(r - d) is d - r.
   always_comb begin
      rem_nz = |in_data.rem;
      differ = in_data.neg_a ^ in_data.neg_b;
      if (!differ) begin
         quo_in = in_data.nq;
      end else if (rem_nz) begin
         quo_in = ~in_data.nq;
      end else begin
         quo_in = '0 - in_data.nq;
      end
      if (differ && rem_nz) begin
         sub_a = in_data.neg_a ? in_data.dsr : in_data.rem;
         sub_b = in_data.neg_a ? in_data.rem : in_data.dsr;
      end else begin
         sub_a = in_data.neg_a ? '0 : in_data.rem;
         sub_b = in_data.neg_a ? in_data.rem : '0;
      end
      rem_in = sub_a - sub_b;
   end

   assign in_ready      = !valid_ff || out_ready;
   assign out_valid     = valid_ff;
   assign out_quotient  = quo_ff;
   assign out_remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule
